// File: design/smcd_pkg.sv
// ----------------------------------------------------------------------------
// smcd_pkg
// Shared types and constants of the serial memory command decoder.
// ----------------------------------------------------------------------------
package smcd_pkg;

    localparam int ADDR_BITS = 16;
    localparam longint MEM_DEPTH = 64'd1 << ADDR_BITS;

    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CMD_CONSOLE = 8'h01;
    localparam logic [7:0] CMD_FW_REQ  = 8'h02;
    localparam logic [7:0] CMD_WRITE   = 8'h03;
    localparam logic [7:0] CMD_READ    = 8'h04;
    localparam logic [7:0] RESP_HEADER = 8'h05;
    localparam logic [7:0] CMD_START   = 8'h20;

    localparam logic OP_RX_BYTE = 1'b0;
    localparam logic OP_TX_SLOT = 1'b1;

    typedef enum logic [2:0] {
        KIND_CONSOLE = 3'd0,
        KIND_FW_REQ  = 3'd1,
        KIND_RESP    = 3'd2,
        KIND_UNKNOWN = 3'd3,
        KIND_BUSY    = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        logic       last;
        logic       start_acked;
    } t_result;

endpackage

// File: design/smcd_out_fifo.sv
// ----------------------------------------------------------------------------
// smcd_out_fifo
// Small result queue between the decode stage and the output channel.
// ----------------------------------------------------------------------------
module smcd_out_fifo (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  smcd_pkg::t_result              i_data,
    input  logic                           i_pop,
    output logic                           o_valid,
    output smcd_pkg::t_result              o_data,
    output logic [smcd_pkg::FIFO_CNT_W-1:0] o_count
);
    import smcd_pkg::*;

    t_result                 r_entry [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   r_wr_ptr;
    logic [FIFO_PTR_W-1:0]   r_rd_ptr;
    logic [FIFO_CNT_W-1:0]   r_count;
    logic [FIFO_PTR_W-1:0]   n_wr_ptr;
    logic [FIFO_PTR_W-1:0]   n_rd_ptr;
    logic [FIFO_CNT_W-1:0]   n_count;

    localparam logic [FIFO_PTR_W-1:0] PTR_LAST = FIFO_PTR_W'(FIFO_DEPTH - 1);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_entry[r_rd_ptr];
    assign o_count = r_count;

endmodule

// File: design/serial_memory_command_decoder_unit.sv
// ----------------------------------------------------------------------------
// serial_memory_command_decoder_unit
// Command parser for a serial byte stream with a byte memory that is written
// by write commands and read back by read responses on transmit slots.
//
//   channel | valid   | stall   | payload
//   --------+---------+---------+-------------------------------------------
//   in      | i_valid | o_stall | i_opcode, i_rx_byte
//   out     | o_valid | i_stall | o_kind, o_value, o_response_last,
//           |         |         | o_start_acked
//
// One transaction per cycle while o_stall is low. A result passes through the
// decode and memory read registers and then the result queue to the output.
// After reset the memory is cleared, one byte a cycle, over all 2^ADDR_BITS
// addresses (65536) while o_stall is high.
// A three-entry result queue raises o_stall once three results are in flight.
// ----------------------------------------------------------------------------
module serial_memory_command_decoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_opcode,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_kind,
    output logic [7:0] o_value,
    output logic       o_response_last,
    output logic       o_start_acked
);
    import smcd_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_CON_SIZE = 3'd1,
        PH_CON_DATA = 3'd2,
        PH_FW_SIZE  = 3'd3,
        PH_ADDR     = 3'd4,
        PH_LEN      = 3'd5,
        PH_PAYLOAD  = 3'd6
    } t_phase;

    logic [7:0]           r_mem [MEM_DEPTH];
    logic [7:0]           r_mem_q;

    t_phase               r_phase;
    logic                 r_cmd_wr;
    logic [2:0]           r_field_idx;
    logic [ADDR_BITS-1:0] r_target;
    logic [15:0]          r_remain;
    logic [16:0]          r_resp_rem;
    logic [ADDR_BITS-1:0] r_resp_addr;
    logic                 r_resp_hdr;
    logic                 r_start;
    logic                 r_clr_busy;
    logic [ADDR_BITS-1:0] r_clr_addr;
    logic                 r_s1_valid;
    logic                 r_s1_use_mem;
    t_result              r_s1;

    t_phase               n_phase;
    logic                 n_cmd_wr;
    logic [2:0]           n_field_idx;
    logic [ADDR_BITS-1:0] n_target;
    logic [15:0]          n_remain;
    logic [16:0]          n_resp_rem;
    logic [ADDR_BITS-1:0] n_resp_addr;
    logic                 n_resp_hdr;
    logic                 n_start;
    logic                 n_s1_valid;
    logic                 n_s1_use_mem;
    t_result              n_s1;

    logic                 in_acc;
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_waddr;
    logic [7:0]           mem_wdata;
    logic                 mem_re;
    logic [63:0]          addr_shift;
    logic [15:0]          len_new;
    logic [15:0]          remain_dec;
    t_result              push_data;
    t_result              out_data;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic                 out_pop;

    assign o_stall = r_clr_busy ||
                     ((FIFO_CNT_W + 1)'(fifo_count) + (FIFO_CNT_W + 1)'(r_s1_valid)
                      >= (FIFO_CNT_W + 1)'(FIFO_DEPTH));
    assign in_acc     = i_valid && !o_stall;
    assign addr_shift = 64'(i_rx_byte) << {r_field_idx, 3'b000};
    assign len_new    = {r_remain[7:0], i_rx_byte};
    assign remain_dec = r_remain - 16'd1;

    always_comb begin
        n_phase      = r_phase;
        n_cmd_wr     = r_cmd_wr;
        n_field_idx  = r_field_idx;
        n_target     = r_target;
        n_remain     = r_remain;
        n_resp_rem   = r_resp_rem;
        n_resp_addr  = r_resp_addr;
        n_resp_hdr   = r_resp_hdr;
        n_start      = r_start;
        n_s1_valid   = 1'b0;
        n_s1_use_mem = 1'b0;
        n_s1.kind    = KIND_UNKNOWN;
        n_s1.value   = i_rx_byte;
        n_s1.last    = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = r_target;
        mem_wdata    = i_rx_byte;
        mem_re       = 1'b0;

        if (in_acc) begin
            if (i_opcode == OP_TX_SLOT) begin
                if (r_resp_rem != '0) begin
                    n_s1_valid = 1'b1;
                    n_s1.kind  = KIND_RESP;
                    n_s1.last  = (r_resp_rem == 17'd1);
                    n_resp_rem = r_resp_rem - 17'd1;
                    if (r_resp_hdr) begin
                        n_resp_hdr = 1'b0;
                        n_s1.value = RESP_HEADER;
                    end else begin
                        n_s1_use_mem = 1'b1;
                        mem_re       = 1'b1;
                        n_resp_addr  = r_resp_addr + 1'b1;
                    end
                end
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                        n_field_idx = '0;
                        n_cmd_wr    = (i_rx_byte == CMD_WRITE);
                        unique case (i_rx_byte) inside
                            CMD_CONSOLE: n_phase = PH_CON_SIZE;
                            CMD_FW_REQ:  n_phase = PH_FW_SIZE;
                            CMD_WRITE, CMD_READ: begin
                                n_target = '0;
                                n_phase  = PH_ADDR;
                            end
                            default: begin
                                if (i_rx_byte == CMD_START) begin
                                    n_start = 1'b1;
                                end
                                n_s1_valid = 1'b1;
                                n_s1.kind  = KIND_UNKNOWN;
                            end
                        endcase
                    end
                    PH_CON_SIZE: begin
                        n_remain = 16'(i_rx_byte);
                        n_phase  = (i_rx_byte == 8'd0) ? PH_IDLE : PH_CON_DATA;
                    end
                    PH_CON_DATA: begin
                        n_remain   = remain_dec;
                        if (remain_dec == '0) begin
                            n_phase = PH_IDLE;
                        end
                        n_s1_valid = 1'b1;
                        n_s1.kind  = KIND_CONSOLE;
                    end
                    PH_FW_SIZE: begin
                        n_phase    = PH_IDLE;
                        n_s1_valid = 1'b1;
                        n_s1.kind  = KIND_FW_REQ;
                    end
                    PH_ADDR: begin
                        n_target    = r_target | addr_shift[ADDR_BITS-1:0];
                        n_field_idx = r_field_idx + 3'd1;
                        if (r_field_idx == 3'd7) begin
                            n_field_idx = '0;
                            n_remain    = '0;
                            n_phase     = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        n_remain    = len_new;
                        n_field_idx = r_field_idx + 3'd1;
                        if (r_field_idx != 3'd0) begin
                            n_field_idx = '0;
                            n_phase     = PH_IDLE;
                            if (r_cmd_wr) begin
                                if (len_new != '0) begin
                                    n_phase = PH_PAYLOAD;
                                end
                            end else if (r_resp_rem != '0) begin
                                n_s1_valid = 1'b1;
                                n_s1.kind  = KIND_BUSY;
                                n_s1.value = CMD_READ;
                            end else begin
                                n_resp_rem  = 17'(len_new) + 17'd1;
                                n_resp_addr = r_target;
                                n_resp_hdr  = 1'b1;
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        mem_we   = 1'b1;
                        n_target = r_target + 1'b1;
                        n_remain = remain_dec;
                        if (remain_dec == '0) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end

        n_s1.start_acked = n_start;

        if (r_clr_busy) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_cmd_wr    <= 1'b0;
            r_field_idx <= '0;
            r_target    <= '0;
            r_remain    <= '0;
            r_resp_rem  <= '0;
            r_resp_addr <= '0;
            r_resp_hdr  <= 1'b0;
            r_start     <= 1'b0;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_cmd_wr    <= n_cmd_wr;
            r_field_idx <= n_field_idx;
            r_target    <= n_target;
            r_remain    <= n_remain;
            r_resp_rem  <= n_resp_rem;
            r_resp_addr <= n_resp_addr;
            r_resp_hdr  <= n_resp_hdr;
            r_start     <= n_start;
            r_s1_valid  <= n_s1_valid;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1         <= n_s1;
        r_s1_use_mem <= n_s1_use_mem;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[r_resp_addr];
        end
    end

    always_comb begin
        push_data = r_s1;
        if (r_s1_use_mem) begin
            push_data.value = r_mem_q;
        end
    end

    assign out_pop = o_valid && !i_stall;

    smcd_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_data  (push_data),
        .i_pop   (out_pop),
        .o_valid (o_valid),
        .o_data  (out_data),
        .o_count (fifo_count)
    );

    assign o_kind          = out_data.kind;
    assign o_value         = out_data.value;
    assign o_response_last = out_data.last;
    assign o_start_acked   = out_data.start_acked;

endmodule
